FILE: hw/rtl/qdee_pkg.sv
package qdee_pkg;

    // field widths
    localparam int SAMPLE_W  = 40;
    localparam int SCALE_W   = 3;
    localparam int BYTE_W    = 8;
    localparam int Q_W       = 32;
    localparam int ESC_W     = 16;

    // fraction bits of the incoming sample
    localparam int FRAC_BITS = 8;

    localparam logic [SCALE_W-1:0] MAX_SCALE = 3'd4;

    // rounding numerator 2*mag + den
    localparam int DEN_W = SAMPLE_W + 1;
    localparam int POW_W = 14;

    // chunked division by 5^k
    localparam int CHUNK_W    = 14;
    localparam int NUM_CHUNKS = 3;
    localparam int DIV_W      = CHUNK_W * NUM_CHUNKS;
    localparam int REM_W      = 10;
    localparam int V_W        = REM_W + CHUNK_W;
    localparam int RECIP_W    = 35;
    localparam int SHIFT_S    = 34;
    localparam int PROD_W     = V_W + RECIP_W;

    localparam logic [BYTE_W-1:0] ESCAPE_CODE = 8'hff;
    localparam logic [BYTE_W-1:0] DELTA_BIAS  = 8'd128;
    localparam int DELTA_HIGH  = 127;
    localparam int DELTA_LOW   = -128;
    localparam int ESC_OFFSET  = 32768;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    // one quantized request handed from the datapath to the output stage
    typedef struct packed {
        logic           vld;
        cmd_t           cmd;
        logic [Q_W-1:0] q;
    } qdee_item_t;

    function automatic logic [POW_W-1:0] pow_ten(input logic [SCALE_W-1:0] k);
        case (k)
            3'd0:    return 14'd1;
            3'd1:    return 14'd10;
            3'd2:    return 14'd100;
            3'd3:    return 14'd1000;
            default: return 14'd10000;
        endcase
    endfunction

    // 10^k * 2^frac, the rounding term and the full divisor before halving
    function automatic logic [DEN_W-1:0] round_den(input logic [SCALE_W-1:0] k);
        logic [DEN_W-1:0] p;
        p = {{(DEN_W-POW_W){1'b0}}, pow_ten(k)};
        return p << FRAC_BITS;
    endfunction

    function automatic logic [REM_W-1:0] divisor(input logic [SCALE_W-1:0] k);
        case (k)
            3'd0:    return 10'd1;
            3'd1:    return 10'd5;
            3'd2:    return 10'd25;
            3'd3:    return 10'd125;
            default: return 10'd625;
        endcase
    endfunction

    // ceil(2^SHIFT_S / 5^k), exact for chunk values below 5^k * 2^CHUNK_W
    function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] k);
        case (k)
            3'd0:    return 35'd17179869184;
            3'd1:    return 35'd3435973837;
            3'd2:    return 35'd687194768;
            3'd3:    return 35'd137438954;
            default: return 35'd27487791;
        endcase
    endfunction

endpackage

FILE: hw/rtl/qdee_quant.sv
module qdee_quant (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  command,
    input  logic [qdee_pkg::SCALE_W-1:0]          scale_mode,
    input  logic signed [qdee_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic                                  adv,
    output qdee_pkg::qdee_item_t                  item
);
    import qdee_pkg::*;

    typedef struct packed {
        logic               vld;
        cmd_t               cmd;
        logic               neg;
        logic [SCALE_W-1:0] k;
        logic [DIV_W-1:0]   y;
        logic [DIV_W-1:0]   quo;
    } stage_t;

    logic [SCALE_W-1:0]  mode_reg;
    logic [SCALE_W-1:0]  mode_sat;
    logic                s0_vld_reg;
    cmd_t                s0_cmd_reg;
    logic [SCALE_W-1:0]  s0_k_reg;
    logic [SAMPLE_W-1:0] s0_sample_reg;

    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] mag;
    logic [DEN_W-1:0]    num;
    logic [DEN_W-1:0]    num_shift;
    logic [SAMPLE_W-1:0] y_shift;
    stage_t              s1_next;
    stage_t              s1_reg;

    stage_t              a_reg    [NUM_CHUNKS];
    logic [V_W-1:0]      av_reg   [NUM_CHUNKS];
    logic [PROD_W-1:0]   prod_reg [NUM_CHUNKS];
    stage_t              b_reg    [NUM_CHUNKS];
    logic [V_W-1:0]      bv_reg   [NUM_CHUNKS];
    logic [V_W-1:0]      p2_reg   [NUM_CHUNKS];

    stage_t              fin;
    logic                pos_ovf;
    logic                neg_ovf;
    qdee_item_t          item_next;
    qdee_item_t          item_reg;

    assign mode_sat = (scale_mode > MAX_SCALE) ? MAX_SCALE : scale_mode;

    // input register and latched scale mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            mode_reg   <= '0;
        end
        else if (adv)
        begin
            s0_vld_reg <= in_valid;
            if (in_valid && cmd_t'(command) == CMD_START)
            begin
                mode_reg <= mode_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_cmd_reg    <= cmd_t'(command);
            s0_k_reg      <= mode_reg;
            s0_sample_reg <= sample_value;
        end
    end

    // magnitude, rounding term, divide by 2^(frac+1) and 2^k
    always_comb
    begin
        raw       = s0_sample_reg;
        mag       = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
        num       = {mag, 1'b0} + round_den(s0_k_reg);
        num_shift = num >> (FRAC_BITS + 1);
        y_shift   = num_shift[SAMPLE_W-1:0] >> s0_k_reg;
        s1_next.vld = s0_vld_reg;
        s1_next.cmd = s0_cmd_reg;
        s1_next.neg = raw[SAMPLE_W-1];
        s1_next.k   = s0_k_reg;
        s1_next.y   = {{(DIV_W-SAMPLE_W){1'b0}}, y_shift};
        s1_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= s1_next;
        end
    end

    // long division by 5^k, one chunk per stage pair
    for (genvar c = 0; c < NUM_CHUNKS; c++)
    begin : g_chunk
        stage_t             a_in;
        logic [REM_W-1:0]   r_prev;
        logic [CHUNK_W-1:0] chunk;
        logic [V_W-1:0]     v;
        logic [CHUNK_W-1:0] qd;
        stage_t             b_next;

        if (c == 0)
        begin : g_first
            assign a_in   = s1_reg;
            assign r_prev = '0;
        end
        else
        begin : g_rest
            logic [V_W-1:0] diff;
            assign a_in   = b_reg[c-1];
            assign diff   = bv_reg[c-1] - p2_reg[c-1];
            assign r_prev = diff[REM_W-1:0];
        end

        assign chunk = a_in.y[DIV_W-1-c*CHUNK_W -: CHUNK_W];
        assign v     = {r_prev, chunk};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_reg[c] <= '0;
            end
            else if (adv)
            begin
                a_reg[c] <= a_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                av_reg[c]   <= v;
                prod_reg[c] <= PROD_W'(v) * PROD_W'(recip(a_in.k));
            end
        end

        assign qd = prod_reg[c][SHIFT_S +: CHUNK_W];

        always_comb
        begin
            b_next     = a_reg[c];
            b_next.quo = {a_reg[c].quo[DIV_W-CHUNK_W-1:0], qd};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                b_reg[c] <= '0;
            end
            else if (adv)
            begin
                b_reg[c] <= b_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                bv_reg[c] <= av_reg[c];
                p2_reg[c] <= V_W'(qd) * V_W'(divisor(a_reg[c].k));
            end
        end
    end

    // sign and 32-bit saturation
    always_comb
    begin
        fin     = b_reg[NUM_CHUNKS-1];
        pos_ovf = |fin.quo[DIV_W-1:Q_W-1];
        neg_ovf = (|fin.quo[DIV_W-1:Q_W]) || (fin.quo[Q_W-1] && (|fin.quo[Q_W-2:0]));
        item_next.vld = fin.vld;
        item_next.cmd = fin.cmd;
        if (fin.neg)
        begin
            item_next.q = neg_ovf ? {1'b1, {(Q_W-1){1'b0}}} : (~fin.quo[Q_W-1:0] + 1'b1);
        end
        else
        begin
            item_next.q = pos_ovf ? {1'b0, {(Q_W-1){1'b1}}} : fin.quo[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

FILE: hw/rtl/qdee_out.sv
module qdee_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qdee_pkg::qdee_item_t          item,
    input  logic                          out_stall,
    output logic                          adv,
    output logic                          out_valid,
    output logic [qdee_pkg::BYTE_W-1:0]   code_byte,
    output logic                          last_of_run
);
    import qdee_pkg::*;

    localparam logic signed [Q_W:0] D_HI = (Q_W+1)'(DELTA_HIGH);
    localparam logic signed [Q_W:0] D_LO = (Q_W+1)'(DELTA_LOW);
    localparam logic signed [Q_W:0] OFS  = (Q_W+1)'(ESC_OFFSET);

    logic [Q_W-1:0]    prev_reg;
    logic [Q_W-1:0]    prev_next;
    logic signed [Q_W:0] delta;
    logic signed [Q_W:0] usum;
    logic              escape;
    logic [ESC_W-1:0]  us;
    logic              load;
    logic              take;

    logic [1:0]        rem_reg;
    logic [1:0]        rem_next;
    logic [BYTE_W-1:0] b0_reg, b1_reg, b2_reg;
    logic [BYTE_W-1:0] b0_next, b1_next, b2_next;

    always_comb
    begin
        delta  = $signed({item.q[Q_W-1], item.q}) - $signed({prev_reg[Q_W-1], prev_reg});
        usum   = $signed({item.q[Q_W-1], item.q}) + OFS;
        escape = (delta >= D_HI) || (delta < D_LO);
        if (usum[Q_W])
        begin
            us = '0;
        end
        else if (|usum[Q_W-1:ESC_W])
        begin
            us = '1;
        end
        else
        begin
            us = usum[ESC_W-1:0];
        end
    end

    assign out_valid   = (rem_reg != 2'd0);
    assign last_of_run = (rem_reg == 2'd1);
    assign code_byte   = b0_reg;
    assign take        = out_valid && !out_stall;
    assign adv         = (rem_reg == 2'd0) || (rem_reg == 2'd1 && !out_stall);
    assign load        = adv && item.vld && item.cmd == CMD_SAMPLE;

    always_comb
    begin
        rem_next  = rem_reg;
        b0_next   = b0_reg;
        b1_next   = b1_reg;
        b2_next   = b2_reg;
        prev_next = prev_reg;
        if (adv && item.vld)
        begin
            prev_next = (item.cmd == CMD_START) ? '0 : item.q;
        end
        if (load)
        begin
            if (escape)
            begin
                rem_next = 2'd3;
                b0_next  = ESCAPE_CODE;
                b1_next  = us[ESC_W-1:BYTE_W];
                b2_next  = us[BYTE_W-1:0];
            end
            else
            begin
                rem_next = 2'd1;
                b0_next  = delta[BYTE_W-1:0] + DELTA_BIAS;
            end
        end
        else if (take)
        begin
            rem_next = rem_reg - 2'd1;
            b0_next  = b1_reg;
            b1_next  = b2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 2'd0;
            prev_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

endmodule

FILE: hw/rtl/quantized_delta_escape_encoder.sv
// quantized delta encoder with escape code
//
// input channel (in_valid / in_stall): one request per accepted edge.
//   command start latches scale_mode (saturated to 4) and clears the predictor;
//   command sample quantizes sample_value (8 fraction bits) by 10^-k with
//   rounding half away from zero and encodes it against the predictor
// output channel (out_valid / out_stall): one code byte per accepted edge,
//   last_of_run marks the final byte of a sample; a small delta gives one byte,
//   otherwise escape 0xff then high and low byte of the saturated value+32768
// pipeline: the first byte of a sample reaches out_valid through the input
//   register, scaling stage, three two-stage chunk divider steps, saturation
//   stage and output byte register
// throughput: one request per cycle while samples encode to one byte and
//   out_stall stays low; an escaped sample holds the byte register until all
//   three bytes are taken, a start request takes one pipeline slot and emits nothing
// stall: while the byte register holds a byte that is not the last of its run,
//   or a last byte under out_stall, the whole pipeline freezes and in_stall
//   rises; a last byte being handed off frees a slot
// reset: asynchronous, clears all valid bits, scale mode 0 and predictor 0
module quantized_delta_escape_encoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [qdee_pkg::SCALE_W-1:0]          scale_mode,
    input  logic signed [qdee_pkg::SAMPLE_W-1:0]  sample_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [qdee_pkg::BYTE_W-1:0]           code_byte,
    output logic                                  last_of_run
);
    import qdee_pkg::*;

    // pipeline advance, driven by the byte register
    logic       adv;
    qdee_item_t item;

    // scaling and exact division by 10^k, saturated to 32 bits
    qdee_quant u_quant (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .command      (command),
        .scale_mode   (scale_mode),
        .sample_value (sample_value),
        .adv          (adv),
        .item         (item)
    );

    // predictor, delta or escape decision, byte serializer
    qdee_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .out_stall   (out_stall),
        .adv         (adv),
        .out_valid   (out_valid),
        .code_byte   (code_byte),
        .last_of_run (last_of_run)
    );

    // requests are held off only while a byte waits in the output register
    assign in_stall = !adv;

`ifndef SYNTH
    // a held-off request always means a byte is pending on the output
    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending output byte");

    // a run that is not finished keeps delivering bytes
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("escape run broken before its last byte");

    // no request is accepted while a non-final byte is pending on the output
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> in_stall)
        else $error("request accepted while an escape run is pending");
`endif

endmodule

FILE: bench/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import qdee_pkg::*;

    // cycles with no handshake on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet cycles after the last byte, well past the pipeline depth
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 75;
    localparam int MAX_GAP        = 17;

    // one expected output byte
    typedef struct {
        logic [BYTE_W-1:0] code;
        logic              last;
    } code_rec_t;

    // one directed request; lit_count above zero means the bytes are typed in
    typedef struct {
        cmd_t                     cmd;
        logic [SCALE_W-1:0]       mode;
        logic [SAMPLE_W-1:0]      value;
        int                       lit_count;
        logic [2:0][BYTE_W-1:0]   lit;
    } directed_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         command = 1'b0;
    logic [SCALE_W-1:0]           scale_mode = '0;
    logic signed [SAMPLE_W-1:0]   sample_value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [BYTE_W-1:0]            code_byte;
    logic                         last_of_run;

    // predictor state: quantized predictor and latched scale index
    logic signed [Q_W-1:0]        prev_quant = '0;
    logic [SCALE_W-1:0]           cur_scale = '0;

    code_rec_t                    pending_codes[$];
    directed_row_t                directed_rows[$];

    // handshakes seen at the falling edge, taken at the next rising edge
    logic                         in_take = 1'b0;
    logic                         out_take = 1'b0;
    logic [BYTE_W-1:0]            seen_code = '0;
    logic                         seen_last = 1'b0;

    int                           mismatches = 0;
    int                           idle_cycles = 0;
    // when set, both sides run without gaps or stalls
    bit                           calm = 1'b0;

    quantized_delta_escape_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .scale_mode   (scale_mode),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_byte    (code_byte),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    // everything settles between edges, so the falling edge sees what the
    // next rising edge will act on
    always @(negedge clk)
    begin
        in_take   = in_valid && !in_stall;
        out_take  = out_valid && !out_stall;
        seen_code = code_byte;
        seen_last = last_of_run;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ten to the k
    function automatic longint decade(input logic [SCALE_W-1:0] k);
        case (k)
            3'd0:    return 64'd1;
            3'd1:    return 64'd10;
            3'd2:    return 64'd100;
            3'd3:    return 64'd1000;
            default: return 64'd10000;
        endcase
    endfunction

    // divide by 2^frac * 10^k, round half away from zero, clamp to 32 bits
    function automatic longint quantize_sample(input logic [SAMPLE_W-1:0] raw,
                                               input logic [SCALE_W-1:0] k);
        logic [SAMPLE_W:0] mag;
        longint            den;
        longint            q;
        mag = raw[SAMPLE_W-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
        den = decade(k) << FRAC_BITS;
        q   = (2 * longint'(mag) + den) / (2 * den);
        if (raw[SAMPLE_W-1])
        begin
            if (q > 64'd2147483648)
                q = 64'd2147483648;
            return -q;
        end
        if (q > 64'd2147483647)
            q = 64'd2147483647;
        return q;
    endfunction

    // advance the predictor by one request and produce the bytes it causes
    task automatic encode_request(input cmd_t cmd, input logic [SCALE_W-1:0] mode,
                                  input logic [SAMPLE_W-1:0] value,
                                  output int count, output logic [2:0][BYTE_W-1:0] bytes);
        longint q;
        longint delta;
        longint biased;
        bytes = '0;
        count = 0;
        if (cmd == CMD_START)
        begin
            cur_scale  = (mode > MAX_SCALE) ? MAX_SCALE : mode;
            prev_quant = '0;
            return;
        end
        q          = quantize_sample(value, cur_scale);
        delta      = q - longint'(prev_quant);
        prev_quant = q[Q_W-1:0];
        if (delta >= DELTA_HIGH || delta < DELTA_LOW)
        begin
            biased = q + ESC_OFFSET;
            if (biased < 0)
                biased = 0;
            if (biased > 65535)
                biased = 65535;
            bytes[0] = ESCAPE_CODE;
            bytes[1] = biased[15:8];
            bytes[2] = biased[7:0];
            count    = 3;
        end
        else
        begin
            biased   = delta + longint'(DELTA_BIAS);
            bytes[0] = biased[BYTE_W-1:0];
            count    = 1;
        end
    endtask

    task automatic add_row(input cmd_t cmd, input logic [SCALE_W-1:0] mode,
                           input logic [SAMPLE_W-1:0] value, input int lit_count,
                           input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                           input logic [BYTE_W-1:0] b2);
        directed_row_t row;
        row.cmd       = cmd;
        row.mode      = mode;
        row.value     = value;
        row.lit_count = lit_count;
        row.lit       = {b2, b1, b0};
        directed_rows.push_back(row);
    endtask

    // present one request, hold it until taken, then queue its bytes
    task automatic send_request(input cmd_t cmd, input logic [SCALE_W-1:0] mode,
                                input logic [SAMPLE_W-1:0] value, input int lit_count,
                                input logic [2:0][BYTE_W-1:0] lit);
        int                     gap;
        int                     count;
        logic [2:0][BYTE_W-1:0] bytes;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        scale_mode   <= mode;
        sample_value <= value;
        @(posedge clk);
        while (!in_take)
            @(posedge clk);
        encode_request(cmd, mode, value, count, bytes);
        // typed-in rows override the bytes, the predictor state still moves
        if (lit_count > 0)
        begin
            count = lit_count;
            bytes = lit;
        end
        for (int i = 0; i < count; i++)
            pending_codes.push_back('{code: bytes[i], last: (i == count - 1)});
    endtask

    // hold the sender until every queued byte has come out
    task automatic drain_outputs();
        if (pending_codes.size() != 0)
        begin
            in_valid <= 1'b0;
            while (pending_codes.size() != 0)
                @(posedge clk);
        end
    endtask

    // output checker: each taken byte against the oldest expectation
    always @(posedge clk)
    begin : byte_check
        code_rec_t want;
        if (out_take)
        begin
            if (pending_codes.size() == 0)
                report_mismatch($sformatf("unexpected byte %h last %b", seen_code, seen_last));
            else
            begin
                want = pending_codes.pop_front();
                if (seen_code !== want.code)
                    report_mismatch($sformatf("code_byte %h, want %h", seen_code, want.code));
                if (seen_last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b", seen_last, want.last));
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (in_take || out_take)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quantized_delta_escape_encoder test failed");
            $finish;
        end
    end

    // receiver: a random stall before every byte, none while calm
    initial
    begin : receiver
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_take)
                @(posedge clk);
        end
    end

    // stimulus: directed table, then random requests
    initial
    begin : stimulus
        int                     pick;
        longint                 den;
        longint                 target;
        longint                 value;
        logic [63:0]            noise;
        cmd_t                   cmd;
        logic [SCALE_W-1:0]     mode;
        logic [SAMPLE_W-1:0]    sample;

        // sample before any start: scale 0, predictor 0
        add_row(CMD_SAMPLE, 3'd0, 40'sd0,             1, 8'h80, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd5, 40'sd256,           1, 8'h81, 8'h00, 8'h00);
        // full-scale samples: quantized value reaches the 32-bit limit, escape value saturates
        add_row(CMD_SAMPLE, 3'd0, 40'h7f_ffff_ffff,   3, 8'hff, 8'hff, 8'hff);
        add_row(CMD_SAMPLE, 3'd0, 40'h80_0000_0000,   3, 8'hff, 8'h00, 8'h00);
        // start ignores its sample value
        add_row(CMD_START,  3'd0, 40'h5a_5a5a_5a5a,   0, 8'h00, 8'h00, 8'h00);
        // delta of exactly 127 must escape
        add_row(CMD_SAMPLE, 3'd2, 40'sd32512,         3, 8'hff, 8'h80, 8'h7f);
        add_row(CMD_START,  3'd0, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'sd32256,         1, 8'hfe, 8'h00, 8'h00);
        add_row(CMD_START,  3'd0, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, -40'sd32768,        1, 8'h00, 8'h00, 8'h00);
        add_row(CMD_START,  3'd0, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, -40'sd33024,        3, 8'hff, 8'h7f, 8'h7f);
        // scale mode above four saturates
        add_row(CMD_START,  3'd7, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'sd2560000,       0, 8'h00, 8'h00, 8'h00);
        // rounding half away from zero at scales 1 and 2, a full-scale sample at scale 3
        add_row(CMD_START,  3'd1, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'sd1280,          0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, -40'sd1280,         0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_START,  3'd2, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'sd12800,         0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, -40'sd6399,         0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_START,  3'd3, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'h7f_ffff_ffff,   0, 8'h00, 8'h00, 8'h00);
        // escape value above 16 bits, then a small step from it
        add_row(CMD_START,  3'd0, 40'sd0,             0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'sd10240000,      0, 8'h00, 8'h00, 8'h00);
        add_row(CMD_SAMPLE, 3'd0, 40'sd10240128,      0, 8'h00, 8'h00, 8'h00);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].mode, directed_rows[i].value,
                         directed_rows[i].lit_count, directed_rows[i].lit);

        // let the pipeline empty fully before the random part
        drain_outputs();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_ITEMS / 2)
                drain_outputs();
            pick  = $urandom_range(0, 99);
            noise = {$urandom, $urandom};
            cmd   = CMD_SAMPLE;
            mode  = '0;
            if (pick < 10)
            begin
                // start a new packet at any scale index, junk sample bits
                cmd    = CMD_START;
                mode   = SCALE_W'($urandom_range(0, 7));
                sample = noise[SAMPLE_W-1:0];
            end
            else if (pick < 25)
                sample = noise[SAMPLE_W-1:0];
            else
            begin
                // sample near the predictor, some steps past the one-byte range
                den = decade(cur_scale) << FRAC_BITS;
                if (pick < 80)
                    target = longint'(prev_quant) + $urandom_range(0, 259) - 130;
                else
                    target = longint'(prev_quant) + $urandom_range(0, 140000) - 70000;
                value = target * den;
                if ($urandom_range(0, 7) == 0)
                    value = value + den / 2;
                else
                    value = value + $urandom_range(0, 32'(den / 2 - 1));
                if (value > 64'sd549755813887 || value < -64'sd549755813888)
                    sample = noise[SAMPLE_W-1:0];
                else
                    sample = value[SAMPLE_W-1:0];
            end
            send_request(cmd, mode, sample, 0, '0);
        end
        in_valid <= 1'b0;

        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("quantized_delta_escape_encoder test passed");
        else
            $display("quantized_delta_escape_encoder test failed");
        $finish;
    end

endmodule
